// File: src/ghd_pkg.sv
// Shared types, widths and codes for the grid Hermite derivative block.
// Used by ghd_muldiv, ghd_deriv and grid_hermite_derivative.
package ghd_pkg;

    localparam int VAL_W = 32;           // knot and point values, Q16.16
    localparam int OUT_W = 48;           // derivative results, Q32.16
    localparam int A_W   = OUT_W + 1;    // numerator operand of a scaled division
    localparam int B_W   = VAL_W + 3;    // scale operand
    localparam int C_W   = VAL_W + 1;    // divisor operand
    localparam int P_W   = A_W + B_W;    // product width
    localparam int R_W   = C_W + 1;      // partial remainder width
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int DIM_W = 2;

    localparam int MAX_U_DEF   = 64;
    localparam int MAX_V_DEF   = 64;
    localparam int MAX_DIM_DEF = 3;

    localparam logic signed [B_W-1:0] SCALE_ONE = B_W'(65536);

    typedef enum logic [1:0] {REQ_UKNOT, REQ_VKNOT, REQ_POINT, REQ_QUERY} t_req;
    typedef enum logic [1:0] {ST_OK, ST_RANGE, ST_DEGEN} t_status;
    typedef enum logic [1:0] {REG_UCOUNT, REG_VCOUNT, REG_DIM} t_reg_idx;
    typedef enum logic [1:0] {PH_ROW, PH_DV, PH_DUV} t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_RKU, S_LKU, S_RKV, S_LKV, S_CHK, S_RP, S_LP, S_DST, S_DWT, S_EMIT
    } t_top_state;

    typedef enum logic [2:0] {
        DS_IDLE, DS_ST1, DS_W1, DS_ST2, DS_W2, DS_ST3, DS_W3
    } t_drv_state;

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_FIN} t_md_state;

    // One derivative job: three knots, three values, window degree and node.
    typedef struct packed {
        logic signed [VAL_W-1:0] t0;
        logic signed [VAL_W-1:0] t1;
        logic signed [VAL_W-1:0] t2;
        logic signed [OUT_W-1:0] f0;
        logic signed [OUT_W-1:0] f1;
        logic signed [OUT_W-1:0] f2;
        logic                    deg2;
        logic [1:0]              m;
    } t_deriv_op;

endpackage

// File: src/ghd_muldiv.sv
// Sequential round(a*b/c) with ties away from zero, saturated to 48 bits.
// Shift-add multiply followed by restoring division. Depends on ghd_pkg.
module ghd_muldiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [ghd_pkg::A_W-1:0]   i_a,
    input  logic signed [ghd_pkg::B_W-1:0]   i_b,
    input  logic signed [ghd_pkg::C_W-1:0]   i_c,
    output logic                         o_done,
    output logic signed [ghd_pkg::OUT_W-1:0] o_q
);
    import ghd_pkg::*;

    localparam int CW = $clog2(P_W);

    t_md_state          r_state, n_state;
    logic [P_W-1:0]     r_p;
    logic [P_W-1:0]     r_am;
    logic [B_W-1:0]     r_bm;
    logic [C_W-1:0]     r_cm;
    logic [R_W-1:0]     r_r;
    logic               r_neg;
    logic [CW-1:0]      r_cnt;
    logic               r_done;
    logic signed [OUT_W-1:0] r_q;

    logic [A_W-1:0]     w_am;
    logic [B_W-1:0]     w_bm;
    logic [C_W-1:0]     w_cm;
    logic [R_W-1:0]     w_rs;
    logic               w_ge;
    logic               w_rnd;
    logic [P_W:0]       w_q1;
    logic [P_W:0]       w_lim;
    logic signed [OUT_W-1:0] w_res;
    logic               w_mul, w_div, w_fin;

    assign w_am = i_a[A_W-1] ? A_W'(-i_a) : A_W'(i_a);
    assign w_bm = i_b[B_W-1] ? B_W'(-i_b) : B_W'(i_b);
    assign w_cm = i_c[C_W-1] ? C_W'(-i_c) : C_W'(i_c);

    assign w_rs = {r_r[R_W-2:0], r_p[P_W-1]};
    assign w_ge = w_rs >= {1'b0, r_cm};

    // Round half away from zero on the magnitude, then clamp.
    assign w_rnd = r_r[C_W-1:0] >= (r_cm - r_r[C_W-1:0]);
    assign w_q1  = {1'b0, r_p} + (P_W+1)'(w_rnd);
    assign w_lim = ((P_W+1)'(1) << (OUT_W-1)) - (P_W+1)'(!r_neg);

    always_comb begin
        if (r_cm == '0) begin
            w_res = '0;
        end else if (w_q1 > w_lim) begin
            w_res = r_neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            w_res = r_neg ? -$signed(w_q1[OUT_W-1:0]) : $signed(w_q1[OUT_W-1:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MD_IDLE: if (i_start) n_state = MD_MUL;
            MD_MUL:  if (r_cnt == '0) n_state = MD_DIV;
            MD_DIV:  if (r_cnt == '0) n_state = MD_FIN;
            MD_FIN:  n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    always_comb begin
        w_mul = r_state == MD_MUL;
        w_div = r_state == MD_DIV;
        w_fin = r_state == MD_FIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MD_IDLE && i_start) begin
            r_am  <= P_W'(w_am);
            r_bm  <= w_bm;
            r_cm  <= w_cm;
            r_neg <= i_a[A_W-1] ^ i_b[B_W-1] ^ i_c[C_W-1];
            r_p   <= '0;
            r_r   <= '0;
            r_cnt <= CW'(B_W-1);
        end else if (w_mul) begin
            if (r_bm[0]) r_p <= r_p + r_am;
            r_am  <= r_am << 1;
            r_bm  <= r_bm >> 1;
            r_cnt <= (r_cnt == '0) ? CW'(P_W-1) : r_cnt - 1'b1;
        end else if (w_div) begin
            // The quotient bits shift into the low end as the dividend leaves the top.
            r_r   <= w_ge ? w_rs - {1'b0, r_cm} : w_rs;
            r_p   <= {r_p[P_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end else if (w_fin) begin
            r_q <= w_res;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// File: src/ghd_deriv.sv
// Derivative of a two- or three-knot Lagrange interpolant at one node.
// Runs up to three scaled divisions on one ghd_muldiv. Depends on ghd_pkg.
module ghd_deriv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  ghd_pkg::t_deriv_op           i_op,
    output logic                         o_done,
    output logic signed [ghd_pkg::OUT_W-1:0] o_d
);
    import ghd_pkg::*;

    t_drv_state r_state, n_state;
    logic signed [OUT_W-1:0] r_s1, r_s2, r_d;
    logic                    r_done;

    logic signed [C_W-1:0] w_t0e, w_t1e, w_t2e, w_h1, w_h2, w_h20;
    logic signed [A_W-1:0] w_f0e, w_f1e, w_f2e;
    logic signed [B_W-1:0] w_g;
    logic signed [OUT_W:0] w_sum;
    logic signed [OUT_W-1:0] w_sat;

    logic                    w_md_start, w_md_done;
    logic signed [A_W-1:0]   w_md_a;
    logic signed [B_W-1:0]   w_md_b;
    logic signed [C_W-1:0]   w_md_c;
    logic signed [OUT_W-1:0] w_md_q;

    assign w_t0e = {i_op.t0[VAL_W-1], i_op.t0};
    assign w_t1e = {i_op.t1[VAL_W-1], i_op.t1};
    assign w_t2e = {i_op.t2[VAL_W-1], i_op.t2};
    assign w_h1  = w_t1e - w_t0e;
    assign w_h2  = w_t2e - w_t1e;
    assign w_h20 = w_t2e - w_t0e;
    assign w_f0e = {i_op.f0[OUT_W-1], i_op.f0};
    assign w_f1e = {i_op.f1[OUT_W-1], i_op.f1};
    assign w_f2e = {i_op.f2[OUT_W-1], i_op.f2};

    // Slope correction factor for the node at the left, middle or right knot.
    always_comb begin
        unique case (i_op.m)
            2'd0:    w_g = -B_W'(w_h1);
            2'd1:    w_g = B_W'(w_h1);
            default: w_g = B_W'(w_h20) + B_W'(w_h2);
        endcase
    end

    assign w_sum = {r_s1[OUT_W-1], r_s1} + {w_md_q[OUT_W-1], w_md_q};
    always_comb begin
        if (w_sum[OUT_W] != w_sum[OUT_W-1]) begin
            w_sat = w_sum[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[OUT_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DS_IDLE: if (i_start) n_state = DS_ST1;
            DS_ST1:  n_state = DS_W1;
            DS_W1:   if (w_md_done) n_state = i_op.deg2 ? DS_ST2 : DS_IDLE;
            DS_ST2:  n_state = DS_W2;
            DS_W2:   if (w_md_done) n_state = DS_ST3;
            DS_ST3:  n_state = DS_W3;
            DS_W3:   if (w_md_done) n_state = DS_IDLE;
            default: n_state = DS_IDLE;
        endcase
    end

    always_comb begin
        w_md_start = 1'b0;
        w_md_a     = w_f1e - w_f0e;
        w_md_b     = SCALE_ONE;
        w_md_c     = w_h1;
        unique case (r_state)
            DS_ST1: w_md_start = 1'b1;
            DS_ST2: begin
                w_md_start = 1'b1;
                w_md_a     = w_f2e - w_f1e;
                w_md_c     = w_h2;
            end
            DS_ST3: begin
                w_md_start = 1'b1;
                w_md_a     = {r_s2[OUT_W-1], r_s2} - {r_s1[OUT_W-1], r_s1};
                w_md_b     = w_g;
                w_md_c     = w_h20;
            end
            default: w_md_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_md_done && ((r_state == DS_W1 && !i_op.deg2) || r_state == DS_W3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_md_done) begin
            if (r_state == DS_W1) begin
                r_s1 <= w_md_q;
                r_d  <= w_md_q;
            end else if (r_state == DS_W2) begin
                r_s2 <= w_md_q;
            end else if (r_state == DS_W3) begin
                r_d <= w_sat;
            end
        end
    end

    ghd_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_a     (w_md_a),
        .i_b     (w_md_b),
        .i_c     (w_md_c),
        .o_done  (w_md_done),
        .o_q     (w_md_q)
    );

    assign o_done = r_done;
    assign o_d    = r_d;

endmodule

// File: src/grid_hermite_derivative.sv
// Grid Hermite derivative block: knot and point memories, query sequencer, APB registers.
// A derivative takes one scaled division for a two-knot window and three for a three-knot
// window. A query reads the window knots in u and v, then for each component reads each row's
// points and finds its u derivative, then the v and mixed derivatives; output stalls hold it.
// One item at a time: a new item is taken only while idle. Reset sets u_count 2, v_count 2,
// dimension 3; memories keep their contents.
module grid_hermite_derivative #(
    parameter int MAX_U   = ghd_pkg::MAX_U_DEF,
    parameter int MAX_V   = ghd_pkg::MAX_V_DEF,
    parameter int MAX_DIM = ghd_pkg::MAX_DIM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // u_index[5:0], v_index[11:6], component[13:12], value[45:14], zero fill
    input  logic [47:0]   i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // out_component[1:0], du_value[49:2], dv_value[97:50], duv_value[145:98], zero fill
    output logic [151:0]  o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]    o_m_axis_tuser,
    output logic          o_m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import ghd_pkg::*;

    localparam int UAW = $clog2(MAX_U);
    localparam int VAW = $clog2(MAX_V);
    localparam int PDEPTH = MAX_U * MAX_V * MAX_DIM;
    localparam int PAW = $clog2(PDEPTH);

    function automatic logic [PAW-1:0] pt_addr(input int u, input int v, input int c);
        pt_addr = PAW'((v * MAX_U + u) * MAX_DIM + c);
    endfunction

    // Memories
    logic [VAL_W-1:0] r_umem [MAX_U];
    logic [VAL_W-1:0] r_vmem [MAX_V];
    logic [VAL_W-1:0] r_pmem [PDEPTH];
    logic signed [VAL_W-1:0] r_urd, r_vrd, r_prd;

    // Registers
    logic [CNT_W-1:0] r_ucount, r_vcount;
    logic [DIM_W-1:0] r_dim;

    t_top_state r_state, n_state;
    t_phase     r_ph;
    t_status    r_err;
    logic [IDX_W-1:0] r_ui, r_vi, r_us, r_vs;
    logic             r_ud2, r_vd2;
    logic [1:0]       r_mu, r_mv, r_k, r_j, r_c;
    logic signed [VAL_W-1:0] r_tu [3];
    logic signed [VAL_W-1:0] r_tv [3];
    logic signed [VAL_W-1:0] r_f [3];
    logic signed [VAL_W-1:0] r_col [3];
    logic signed [OUT_W-1:0] r_rowd [3];
    logic signed [OUT_W-1:0] r_dv, r_duv;

    logic                    r_ovalid, r_olast;
    logic [1:0]              r_ocomp;
    t_status                 r_ostat;
    logic signed [OUT_W-1:0] r_odu, r_odv, r_oduv;

    // Input fields
    t_req                    w_req;
    logic [IDX_W-1:0]        w_ui, w_vi;
    logic [1:0]              w_comp;
    logic [VAL_W-1:0]        w_val;
    logic                    w_acc, w_bad, w_degen, w_slot, w_last_c;
    logic [1:0]              w_kend, w_jend;
    logic                    w_udeg2, w_vdeg2;
    logic [IDX_W-1:0]        w_us, w_vs;

    logic                    w_urd_en, w_vrd_en, w_prd_en, w_dstart;
    logic [UAW-1:0]          w_uaddr;
    logic [VAW-1:0]          w_vaddr;
    logic [PAW-1:0]          w_paddr;
    t_deriv_op               w_op;
    logic                    w_ddone;
    logic signed [OUT_W-1:0] w_d;

    assign w_req  = t_req'(i_s_axis_tuser);
    assign w_ui   = i_s_axis_tdata[5:0];
    assign w_vi   = i_s_axis_tdata[11:6];
    assign w_comp = i_s_axis_tdata[13:12];
    assign w_val  = i_s_axis_tdata[45:14];
    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;

    assign w_bad = (int'(r_ucount) < 2) || (int'(r_ucount) > MAX_U) ||
                   (int'(r_vcount) < 2) || (int'(r_vcount) > MAX_V) ||
                   (r_dim == '0) || (int'(r_dim) > MAX_DIM) ||
                   ({1'b0, w_ui} >= r_ucount) || ({1'b0, w_vi} >= r_vcount);

    // Nearest window: start at zero, clamp at the far end, else center on the node.
    assign w_udeg2 = r_ucount > CNT_W'(2);
    assign w_vdeg2 = r_vcount > CNT_W'(2);
    always_comb begin
        if (!w_udeg2 || w_ui == '0) w_us = '0;
        else if ({1'b0, w_ui} == r_ucount - 1'b1) w_us = w_ui - IDX_W'(2);
        else w_us = w_ui - IDX_W'(1);
        if (!w_vdeg2 || w_vi == '0) w_vs = '0;
        else if ({1'b0, w_vi} == r_vcount - 1'b1) w_vs = w_vi - IDX_W'(2);
        else w_vs = w_vi - IDX_W'(1);
    end

    assign w_kend   = r_ud2 ? 2'd2 : 2'd1;
    assign w_jend   = r_vd2 ? 2'd2 : 2'd1;
    assign w_slot   = !r_ovalid || i_m_axis_tready;
    assign w_last_c = (r_err != ST_OK) || ({1'b0, r_c} == {1'b0, r_dim} - 3'd1);
    assign w_degen  = (r_tu[1] == r_tu[0]) || (r_ud2 && (r_tu[2] == r_tu[1] || r_tu[2] == r_tu[0])) ||
                      (r_tv[1] == r_tv[0]) || (r_vd2 && (r_tv[2] == r_tv[1] || r_tv[2] == r_tv[0]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_acc && w_req == REQ_QUERY) n_state = w_bad ? S_EMIT : S_RKU;
            S_RKU:   n_state = S_LKU;
            S_LKU:   n_state = (r_k == w_kend) ? S_RKV : S_RKU;
            S_RKV:   n_state = S_LKV;
            S_LKV:   n_state = (r_k == w_jend) ? S_CHK : S_RKV;
            S_CHK:   n_state = w_degen ? S_EMIT : S_RP;
            S_RP:    n_state = S_LP;
            S_LP:    n_state = (r_k == w_kend + 2'd1) ? S_DST : S_RP;
            S_DST:   n_state = S_DWT;
            S_DWT: begin
                if (w_ddone) begin
                    if (r_ph == PH_DUV) n_state = S_EMIT;
                    else if (r_ph == PH_ROW && r_j != w_jend) n_state = S_RP;
                    else n_state = S_DST;
                end
            end
            S_EMIT:  if (w_slot) n_state = w_last_c ? S_IDLE : S_RP;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_urd_en = r_state == S_RKU;
        w_vrd_en = r_state == S_RKV;
        w_prd_en = r_state == S_RP;
        w_dstart = r_state == S_DST;
        w_uaddr  = UAW'(int'(r_us) + int'(r_k));
        w_vaddr  = VAW'(int'(r_vs) + int'(r_k));
        if (r_k == w_kend + 2'd1) w_paddr = pt_addr(int'(r_ui), int'(r_vs) + int'(r_j), int'(r_c));
        else w_paddr = pt_addr(int'(r_us) + int'(r_k), int'(r_vs) + int'(r_j), int'(r_c));
    end

    always_comb begin
        w_op = '0;
        unique case (r_ph)
            PH_ROW: begin
                w_op.t0 = r_tu[0]; w_op.t1 = r_tu[1]; w_op.t2 = r_tu[2];
                w_op.f0 = OUT_W'(r_f[0]); w_op.f1 = OUT_W'(r_f[1]); w_op.f2 = OUT_W'(r_f[2]);
                w_op.deg2 = r_ud2; w_op.m = r_mu;
            end
            PH_DV: begin
                w_op.t0 = r_tv[0]; w_op.t1 = r_tv[1]; w_op.t2 = r_tv[2];
                w_op.f0 = OUT_W'(r_col[0]); w_op.f1 = OUT_W'(r_col[1]);
                w_op.f2 = OUT_W'(r_col[2]);
                w_op.deg2 = r_vd2; w_op.m = r_mv;
            end
            default: begin
                w_op.t0 = r_tv[0]; w_op.t1 = r_tv[1]; w_op.t2 = r_tv[2];
                w_op.f0 = r_rowd[0]; w_op.f1 = r_rowd[1]; w_op.f2 = r_rowd[2];
                w_op.deg2 = r_vd2; w_op.m = r_mv;
            end
        endcase
    end

    // Memory ports: writes only while idle, reads only while a query runs.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_req == REQ_UKNOT && int'(w_ui) < MAX_U) r_umem[UAW'(w_ui)] <= w_val;
        if (w_acc && w_req == REQ_VKNOT && int'(w_vi) < MAX_V) r_vmem[VAW'(w_vi)] <= w_val;
        if (w_acc && w_req == REQ_POINT && int'(w_ui) < MAX_U && int'(w_vi) < MAX_V &&
            int'(w_comp) < MAX_DIM) begin
            r_pmem[pt_addr(int'(w_ui), int'(w_vi), int'(w_comp))] <= w_val;
        end
        if (w_urd_en) r_urd <= r_umem[w_uaddr];
        if (w_vrd_en) r_vrd <= r_vmem[w_vaddr];
        if (w_prd_en) r_prd <= r_pmem[w_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ucount <= CNT_W'(2);
            r_vcount <= CNT_W'(2);
            r_dim    <= DIM_W'(3);
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && w_slot) r_ovalid <= 1'b1;
            else if (i_m_axis_tready) r_ovalid <= 1'b0;
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    REG_UCOUNT: r_ucount <= pwdata[CNT_W-1:0];
                    REG_VCOUNT: r_vcount <= pwdata[CNT_W-1:0];
                    REG_DIM:    r_dim    <= pwdata[DIM_W-1:0];
                    default:    r_dim    <= r_dim;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_err <= w_bad ? ST_RANGE : ST_OK;
                r_ui  <= w_ui;
                r_vi  <= w_vi;
                r_us  <= w_us;
                r_vs  <= w_vs;
                r_ud2 <= w_udeg2;
                r_vd2 <= w_vdeg2;
                r_mu  <= 2'(w_ui - w_us);
                r_mv  <= 2'(w_vi - w_vs);
                r_k   <= '0;
                r_c   <= '0;
            end
            S_LKU: begin
                r_tu[r_k] <= r_urd;
                r_k <= (r_k == w_kend) ? 2'd0 : r_k + 2'd1;
            end
            S_LKV: begin
                r_tv[r_k] <= r_vrd;
                r_k <= (r_k == w_jend) ? 2'd0 : r_k + 2'd1;
            end
            S_CHK: begin
                if (w_degen) r_err <= ST_DEGEN;
                r_j  <= '0;
                r_k  <= '0;
                r_ph <= PH_ROW;
            end
            S_LP: begin
                if (r_k == w_kend + 2'd1) begin
                    r_col[r_j] <= r_prd;
                    r_k <= '0;
                end else begin
                    r_f[r_k] <= r_prd;
                    r_k <= r_k + 2'd1;
                end
            end
            S_DWT: begin
                if (w_ddone) begin
                    unique case (r_ph)
                        PH_ROW: begin
                            r_rowd[r_j] <= w_d;
                            if (r_j == w_jend) r_ph <= PH_DV;
                            else r_j <= r_j + 2'd1;
                        end
                        PH_DV: begin
                            r_dv <= w_d;
                            r_ph <= PH_DUV;
                        end
                        default: r_duv <= w_d;
                    endcase
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    r_ostat <= r_err;
                    r_olast <= w_last_c;
                    if (r_err != ST_OK) begin
                        r_ocomp <= '0;
                        r_odu   <= '0;
                        r_odv   <= '0;
                        r_oduv  <= '0;
                    end else begin
                        r_ocomp <= r_c;
                        r_odu   <= r_rowd[r_mv];
                        r_odv   <= r_dv;
                        r_oduv  <= r_duv;
                    end
                    r_c  <= r_c + 2'd1;
                    r_j  <= '0;
                    r_k  <= '0;
                    r_ph <= PH_ROW;
                end
            end
            default: r_k <= r_k;
        endcase
    end

    ghd_deriv u_deriv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_op    (w_op),
        .o_done  (w_ddone),
        .o_d     (w_d)
    );

    always_comb begin
        unique case (paddr[3:2])
            REG_UCOUNT: prdata = 32'(r_ucount);
            REG_VCOUNT: prdata = 32'(r_vcount);
            REG_DIM:    prdata = 32'(r_dim);
            default:    prdata = '0;
        endcase
    end

    assign pready          = 1'b1;
    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'b0, r_oduv, r_odv, r_odu, r_ocomp};
    assign o_m_axis_tuser  = r_ostat;
    assign o_m_axis_tlast  = r_olast;

    // An error result always closes its query.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ostat != ST_OK |-> r_olast)
        else $error("error result without last");

    // A derivative finishes only while the sequencer waits for it.
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> r_state == S_DWT)
        else $error("derivative done outside wait state");

    // Store writes never leave the idle state.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_req != REQ_QUERY |=> r_state == S_IDLE)
        else $error("write transfer started a query");

endmodule

// File: bench/grid_hermite_derivative_test.sv
// Self-checking testbench for grid_hermite_derivative: stream writes and queries, APB setup.
// Depends on ghd_pkg and the block; it predicts every result and compares it field by field.
module grid_hermite_derivative_test;
    import ghd_pkg::*;

    typedef struct {
        logic [1:0]  comp;
        logic [47:0] du;
        logic [47:0] dv;
        logic [47:0] duv;
        logic [1:0]  st;
        logic        last;
    } t_deriv_res;

    class deriv_scoreboard;
        longint     u_knots[64];
        longint     v_knots[64];
        longint     points[64*64*3];
        int         u_cnt = 2;
        int         v_cnt = 2;
        int         dims = 3;
        t_deriv_res due_q[$];
        int         errors = 0;

        function void set_reg(t_reg_idx idx, logic [31:0] d);
            case (idx)
                REG_UCOUNT: u_cnt = int'(d[6:0]);
                REG_VCOUNT: v_cnt = int'(d[6:0]);
                REG_DIM:    dims = int'(d[1:0]);
                default: ;
            endcase
        endfunction

        function longint sat48(longint x);
            if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
            if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
            return x;
        endfunction

        // a*b/c exact, rounded half away from zero, saturated to 48 bits.
        function longint scaled_div(longint a, longint b, longint c);
            logic signed [127:0] aa, bb, cc, prod;
            logic [127:0] pm, cm, q, r, lim;
            bit neg;
            aa = a;
            bb = b;
            cc = c;
            if (c == 0) return 0;
            prod = aa * bb;
            neg = (a < 0) ^ (b < 0) ^ (c < 0);
            pm = prod < 0 ? -prod : prod;
            cm = cc < 0 ? -cc : cc;
            q = pm / cm;
            r = pm % cm;
            if (2 * r >= cm) q = q + 1;
            lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
            if (q > lim) return neg ? -64'sh8000_0000_0000 : 64'sh7FFF_FFFF_FFFF;
            return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function longint slope(longint t0, longint t1, longint t2, longint f0, longint f1,
                               longint f2, bit deg2, int m);
            longint s1, s2, g;
            s1 = scaled_div(f1 - f0, 65536, t1 - t0);
            if (!deg2) return s1;
            s2 = scaled_div(f2 - f1, 65536, t2 - t1);
            g = (m == 0) ? -(t1 - t0) : (m == 1) ? (t1 - t0) : (t2 - t0) + (t2 - t1);
            return sat48(s1 + scaled_div(s2 - s1, g, t2 - t0));
        endfunction

        function void push_res(int c, longint du, longint dv, longint duv, t_status st, bit l);
            t_deriv_res e;
            e.comp = c[1:0];
            e.du = du[47:0];
            e.dv = dv[47:0];
            e.duv = duv[47:0];
            e.st = st;
            e.last = l;
            due_q.push_back(e);
        endfunction

        function void note_input(t_req req, int u, int v, int c, logic [31:0] val);
            longint tu[3], tv[3], rowd[3], col[3];
            int us, vs, mu, mv;
            bit u2, v2;
            if (req == REQ_UKNOT) begin
                u_knots[u] = longint'($signed(val));
                return;
            end
            if (req == REQ_VKNOT) begin
                v_knots[v] = longint'($signed(val));
                return;
            end
            if (req == REQ_POINT) begin
                if (c < 3) points[(v*64 + u)*3 + c] = longint'($signed(val));
                return;
            end
            if (u_cnt < 2 || u_cnt > 64 || v_cnt < 2 || v_cnt > 64 || dims < 1 ||
                u >= u_cnt || v >= v_cnt) begin
                push_res(0, 0, 0, 0, ST_RANGE, 1'b1);
                return;
            end
            u2 = u_cnt > 2;
            v2 = v_cnt > 2;
            us = (!u2 || u == 0) ? 0 : (u == u_cnt - 1) ? u - 2 : u - 1;
            vs = (!v2 || v == 0) ? 0 : (v == v_cnt - 1) ? v - 2 : v - 1;
            mu = u - us;
            mv = v - vs;
            for (int k = 0; k < 3; k++) begin
                tu[k] = (k == 2 && !u2) ? 0 : u_knots[us + k];
                tv[k] = (k == 2 && !v2) ? 0 : v_knots[vs + k];
            end
            if (tu[1] == tu[0] || (u2 && (tu[2] == tu[1] || tu[2] == tu[0])) ||
                tv[1] == tv[0] || (v2 && (tv[2] == tv[1] || tv[2] == tv[0]))) begin
                push_res(0, 0, 0, 0, ST_DEGEN, 1'b1);
                return;
            end
            for (int cc = 0; cc < dims; cc++) begin
                rowd[2] = 0;
                col[2] = 0;
                for (int j = 0; j <= (v2 ? 2 : 1); j++) begin
                    rowd[j] = slope(tu[0], tu[1], tu[2], points[((vs+j)*64 + us)*3 + cc],
                                    points[((vs+j)*64 + us + 1)*3 + cc],
                                    u2 ? points[((vs+j)*64 + us + 2)*3 + cc] : 0, u2, mu);
                    col[j] = points[((vs+j)*64 + u)*3 + cc];
                end
                push_res(cc, rowd[mv],
                         slope(tv[0], tv[1], tv[2], col[0], col[1], col[2], v2, mv),
                         slope(tv[0], tv[1], tv[2], rowd[0], rowd[1], rowd[2], v2, mv),
                         ST_OK, cc == dims - 1);
            end
        endfunction

        function void check_result(logic [151:0] td, logic [1:0] tu, logic tl);
            t_deriv_res e;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected result transfer, data %h status %0d last %0b",
                         $time, td, tu, tl);
                errors++;
                return;
            end
            e = due_q.pop_front();
            if (td[1:0] !== e.comp) begin
                $display("%0t: component expected %0d actual %0d", $time, e.comp, td[1:0]);
                errors++;
            end
            if (td[49:2] !== e.du) begin
                $display("%0t: du expected %h actual %h", $time, e.du, td[49:2]);
                errors++;
            end
            if (td[97:50] !== e.dv) begin
                $display("%0t: dv expected %h actual %h", $time, e.dv, td[97:50]);
                errors++;
            end
            if (td[145:98] !== e.duv) begin
                $display("%0t: duv expected %h actual %h", $time, e.duv, td[145:98]);
                errors++;
            end
            if (tu !== e.st) begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, tu);
                errors++;
            end
            if (tl !== e.last) begin
                $display("%0t: last expected %0b actual %0b", $time, e.last, tl);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 40000;
    localparam int HOLD_CYCLES = 6000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_valid = 1'b0;
    logic          o_s_axis_tready;
    logic [47:0]   s_data = '0;
    logic [1:0]    s_user = '0;
    logic          o_m_axis_tvalid;
    logic          m_ready = 1'b0;
    logic [151:0]  o_m_axis_tdata;
    logic [1:0]    o_m_axis_tuser;
    logic          o_m_axis_tlast;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    deriv_scoreboard sb = new();
    bit     idle_on = 1'b1;
    bit     hold_go = 1'b0;
    int     hold_left = 0;
    int     quiet_cycles = 0;
    int     sent_items = 0;
    bit     u_wr[64];
    bit     v_wr[64];
    bit     p_wr[64*64*3];
    longint knot_base;
    longint knot_step;

    grid_hermite_derivative uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser),
        .o_m_axis_tlast(o_m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready)
                sb.note_input(t_req'(s_user), int'(s_data[5:0]), int'(s_data[11:6]),
                              int'(s_data[13:12]), s_data[45:14]);
            if (o_m_axis_tvalid && m_ready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
    end

    // The receiver stalls at random while idle_on is set, and holds off for a long stretch on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_on || $urandom_range(99) >= 11;
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("grid_hermite_derivative_test: done, errors");
            $finish;
        end
    end

    task automatic send_item(t_req req, int u, int v, int c, logic [31:0] val);
        while (idle_on && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= req;
        s_data <= {2'b00, val, 2'(c), 6'(v), 6'(u)};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_items++;
        if (req == REQ_UKNOT) u_wr[u] = 1'b1;
        if (req == REQ_VKNOT) v_wr[v] = 1'b1;
        if (req == REQ_POINT && c < 3) p_wr[(v*64 + u)*3 + c] = 1'b1;
    endtask

    // Drops valid and lets the monitor note the last accepted transfer before waiting for results.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, d);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] knot_value(int i);
        return 32'(knot_base + i * knot_step + $urandom_range(0, int'(knot_step / 2)));
    endfunction

    function automatic logic [31:0] point_value();
        return ($urandom_range(1)) ? $urandom : 32'($urandom_range(0, 1 << 20)) - 32'h8_0000;
    endfunction

    // Writes whatever a query at (u, v) would read that is still unwritten, then queries.
    task automatic query_at(int u, int v);
        int us, vs, un, vn;
        if (sb.u_cnt >= 2 && sb.u_cnt <= 64 && sb.v_cnt >= 2 && sb.v_cnt <= 64 &&
            sb.dims >= 1 && u < sb.u_cnt && v < sb.v_cnt) begin
            un = sb.u_cnt > 2 ? 3 : 2;
            vn = sb.v_cnt > 2 ? 3 : 2;
            us = (un == 2 || u == 0) ? 0 : (u == sb.u_cnt - 1) ? u - 2 : u - 1;
            vs = (vn == 2 || v == 0) ? 0 : (v == sb.v_cnt - 1) ? v - 2 : v - 1;
            for (int k = us; k < us + un; k++)
                if (!u_wr[k]) send_item(REQ_UKNOT, k, $urandom_range(63), 0, knot_value(k));
            for (int j = vs; j < vs + vn; j++)
                if (!v_wr[j]) send_item(REQ_VKNOT, $urandom_range(63), j, 0, knot_value(j));
            for (int j = vs; j < vs + vn; j++)
                for (int k = us; k < us + un; k++)
                    for (int c = 0; c < sb.dims; c++)
                        if (!p_wr[(j*64 + k)*3 + c])
                            send_item(REQ_POINT, k, j, c, point_value());
        end
        send_item(REQ_QUERY, u, v, $urandom_range(3), $urandom);
    endtask

    task automatic set_grid(int uc, int vc, int dm);
        drain_results();
        apb_write(REG_UCOUNT, ($urandom & 32'hFFFF_FF80) | 32'(uc));
        apb_write(REG_VCOUNT, ($urandom & 32'hFFFF_FF80) | 32'(vc));
        apb_write(REG_DIM, ($urandom & 32'hFFFF_FFFC) | 32'(dm));
        knot_step = $urandom_range(3) == 0 ? $urandom_range(1, 4) : $urandom_range(1, 1 << 20);
        knot_base = longint'($urandom_range(0, 1 << 30)) - (longint'(1) << 29);
    endtask

    initial begin
        int grid[11][4] = '{'{3, 3, 3, 60}, '{64, 64, 1, 50}, '{2, 2, 2, 45}, '{1, 2, 3, 8},
                            '{5, 4, 2, 50}, '{64, 3, 3, 45}, '{127, 0, 0, 8}, '{3, 64, 1, 45},
                            '{2, 3, 3, 35}, '{65, 65, 2, 8}, '{4, 4, 3, 26}};
        int n, r, uc, vc, base;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme knots and values on the reset grid, range and degenerate cases.
        send_item(REQ_UKNOT, 0, 63, 3, 32'h8000_0000);
        send_item(REQ_UKNOT, 1, 0, 0, 32'h7FFF_FFFF);
        send_item(REQ_VKNOT, 63, 0, 0, 32'h0000_0000);
        send_item(REQ_VKNOT, 0, 1, 0, 32'h0000_0001);
        for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++)
                for (int c = 0; c < 3; c++)
                    send_item(REQ_POINT, k, j, c, ((j + k + c) % 2) ? 32'h7FFF_FFFF
                                                                   : 32'h8000_0000);
        send_item(REQ_POINT, 63, 63, 3, 32'hFFFF_FFFF);
        query_at(0, 0);
        query_at(1, 1);
        query_at(2, 0);
        query_at(63, 63);
        send_item(REQ_UKNOT, 1, 0, 0, 32'h8000_0000);
        query_at(1, 0);
        send_item(REQ_UKNOT, 1, 0, 0, 32'h0001_0000);
        query_at(0, 1);

        // Each phase sends about its item budget, fill writes included.
        for (int p = 0; p < 11; p++) begin
            set_grid(grid[p][0], grid[p][1], grid[p][2]);
            idle_on = (p != 2);
            uc = (sb.u_cnt >= 2 && sb.u_cnt <= 64) ? sb.u_cnt : 64;
            vc = (sb.v_cnt >= 2 && sb.v_cnt <= 64) ? sb.v_cnt : 64;
            if (p == 1) hold_go = 1'b1;
            n = 0;
            base = sent_items;
            while (sent_items - base < grid[p][3]) begin
                r = $urandom_range(99);
                if (p == 4 && n == 10) drain_results();
                if (r < 55)
                    query_at($urandom_range(uc - 1), $urandom_range(vc - 1));
                else if (r < 63)
                    query_at($urandom_range(63), $urandom_range(63));
                else if (r < 75)
                    send_item(REQ_POINT, $urandom_range(uc - 1), $urandom_range(vc - 1),
                              $urandom_range(3), point_value());
                else if (r < 80)
                    begin
                        r = $urandom_range(uc - 1);
                        send_item(REQ_UKNOT, r, $urandom_range(63), 0, knot_value(r));
                    end
                else if (r < 85)
                    begin
                        r = $urandom_range(vc - 1);
                        send_item(REQ_VKNOT, $urandom_range(63), r, 0, knot_value(r));
                    end
                else if (r < 90)
                    send_item(t_req'($urandom_range(1)), $urandom_range(63),
                              $urandom_range(63), 0, $urandom);
                else
                    send_item(REQ_POINT, $urandom_range(63), $urandom_range(63),
                              $urandom_range(3), $urandom);
                n++;
            end
        end
        idle_on = 1'b1;
        drain_results();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("grid_hermite_derivative_test: done, clean");
        else
            $display("grid_hermite_derivative_test: done, errors");
        $finish;
    end
endmodule
